FILE: hw/rtl/mme_pkg.sv
// Package for the matrix multiply engine: sizes, operation codes and helpers.
// Used by matrix_multiply_engine, mme_seq and mme_cell; depends on nothing.
package mme_pkg;

  localparam int unsigned MaxDimDefault = 8;
  localparam int unsigned IndexCap      = 8;
  localparam int unsigned ValW          = 16;
  localparam int unsigned ProdW         = 32;
  localparam int unsigned SumW          = 35;
  localparam int unsigned DimW          = 4;
  localparam int unsigned IdxW          = 3;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_M_ROWS  = 2'd0,
    CFG_N_INNER = 2'd1,
    CFG_K_COLS  = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_e;

  // Handoff from the sequencer to the cell chain.
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last_t;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic            last_res;
  } seq_t;

endpackage

FILE: hw/rtl/matrix_multiply_engine.sv
// Top level of the fixed-point matrix multiply engine.
// Depends on mme_pkg, mme_ram, mme_seq and mme_cell.
//
// Usage: the input channel takes a beat when start is high and busy low.
// A load-A or load-B beat writes one Q8.8 element at (elem_row, elem_col);
// loads can follow back to back. A start beat walks C = A * B in row-major
// order. The sequencer issues one inner step per cycle into a chain of cells:
// store read, multiply, accumulate. busy stays high while the walk runs and
// until the final result has left the chain. Each result appears on the
// result ports for one cycle marked by result_valid_o; last_result_o flags
// the final one. The receiver cannot stall. Configuration beats (index 0
// m_rows, 1 n_inner, 2 k_cols) are always ready; sizes of 0 act as 1 and sizes
// above the grid act as the grid size. Reset sets all sizes to 4 and idles
// the chain; the element stores hold no defined value until written.
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation_i,
  input  logic [IdxW-1:0]        elem_row_i,
  input  logic [IdxW-1:0]        elem_col_i,
  input  logic signed [ValW-1:0] elem_value_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [DimW-1:0]        cfg_data_i,
  output logic                   result_valid_o,
  output logic [IdxW-1:0]        out_row_o,
  output logic [IdxW-1:0]        out_col_o,
  output logic signed [SumW-1:0] product_value_o,
  output logic                   last_result_o
);

  localparam int unsigned Cap = (MaxDim < IndexCap) ? MaxDim : IndexCap;
  localparam int unsigned AW  = 2 * IdxW;

  logic [DimW-1:0] m_q, n_q, k_q;
  logic accept, go;
  logic [IdxW-1:0] mr, ni, kc, t;
  seq_t ctl0, ctl1, ctl2, ctl3;
  logic signed [ValW-1:0] a_rd, b_rd;
  logic signed [SumW-1:0] prod, acc;
  logic in_grid;

  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;
  assign go = accept && (op_e'(operation_i) == OP_START);
  assign in_grid = (32'(elem_row_i) < MaxDim) && (32'(elem_col_i) < MaxDim);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= DimW'(4);
      n_q <= DimW'(4);
      k_q <= DimW'(4);
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_M_ROWS:  m_q <= cfg_data_i;
        CFG_N_INNER: n_q <= cfg_data_i;
        CFG_K_COLS:  k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp a size to 1..Cap and return it minus one.
  function automatic logic [IdxW-1:0] lim(input logic [DimW-1:0] v);
    logic [DimW-1:0] c;
    c = (v == '0) ? DimW'(1) : ((32'(v) > Cap) ? DimW'(Cap) : v);
    return IdxW'(c - 1'b1);
  endfunction

  assign mr = lim(m_q);
  assign ni = lim(n_q);
  assign kc = lim(k_q);

  mme_seq u_seq (
    .clk_i, .rst_ni, .go_i(go), .mr_i(mr), .ni_i(ni), .kc_i(kc),
    .busy_o(busy), .ctl_o(ctl0), .t_o(t)
  );

  // Element stores; reads address A(r,t) and B(t,c).
  mme_ram #(.Width(ValW), .Depth(64)) u_a (
    .clk_i,
    .we_i(accept && (op_e'(operation_i) == OP_LOAD_A) && in_grid),
    .waddr_i({elem_row_i, elem_col_i}), .wdata_i(elem_value_i),
    .raddr_i(AW'({ctl0.row, t})), .rdata_o(a_rd)
  );
  mme_ram #(.Width(ValW), .Depth(64)) u_b (
    .clk_i,
    .we_i(accept && (op_e'(operation_i) == OP_LOAD_B) && in_grid),
    .waddr_i({elem_row_i, elem_col_i}), .wdata_i(elem_value_i),
    .raddr_i(AW'({t, ctl0.col})), .rdata_o(b_rd)
  );

  // Control stage aligned with the registered store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl0;
    end
  end

  mme_cell #(.DoMul(1'b1)) u_mul (
    .clk_i, .rst_ni, .ctl_i(ctl1), .a_i(a_rd), .b_i(b_rd), .acc_i('0),
    .ctl_o(ctl2), .acc_o(prod)
  );
  mme_cell #(.DoMul(1'b0)) u_acc (
    .clk_i, .rst_ni, .ctl_i(ctl2), .a_i('0), .b_i('0), .acc_i(prod),
    .ctl_o(ctl3), .acc_o(acc)
  );

  // A result leaves on the last inner step of each element.
  assign result_valid_o  = ctl3.valid && ctl3.last_t;
  assign out_row_o       = ctl3.row;
  assign out_col_o       = ctl3.col;
  assign product_value_o = acc;
  assign last_result_o   = ctl3.last_res;

endmodule

FILE: hw/rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mme_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/mme_cell.sv
// One cell of the multiply chain: a registered stage that multiplies or accumulates.
// Depends on mme_pkg.
module mme_cell
  import mme_pkg::*;
#(
  parameter bit DoMul = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  seq_t                   ctl_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [ValW-1:0] b_i,
  input  logic signed [SumW-1:0] acc_i,
  output seq_t                   ctl_o,
  output logic signed [SumW-1:0] acc_o
);

  logic signed [SumW-1:0] acc_d, acc_q;
  seq_t ctl_q;

  // Multiply cell forms the product; accumulate cell keeps a running sum per result.
  always_comb begin
    if (DoMul) begin
      acc_d = SumW'(a_i * b_i);
    end else if (ctl_i.first) begin
      acc_d = acc_i;
    end else begin
      acc_d = acc_q + acc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      acc_q <= acc_d;
    end
  end

  assign ctl_o = ctl_q;
  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/mme_seq.sv
// Walk sequencer: steps row, column and inner index for one multiply.
// Depends on mme_pkg.
module mme_seq
  import mme_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [IdxW-1:0]   mr_i,
  input  logic [IdxW-1:0]   ni_i,
  input  logic [IdxW-1:0]   kc_i,
  output logic              busy_o,
  output seq_t              ctl_o,
  output logic [IdxW-1:0]   t_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_d, state_q;
  logic [IdxW-1:0] r_d, r_q, c_d, c_q, t_d, t_q;
  logic end_t, end_c, end_r;

  // Index limits are the clamped sizes minus one.
  assign end_t = (t_q == ni_i);
  assign end_c = (c_q == kc_i);
  assign end_r = (r_q == mr_i);

  always_comb begin
    state_d = state_q;
    r_d = r_q;
    c_d = c_q;
    t_d = t_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_RUN;
          r_d = '0;
          c_d = '0;
          t_d = '0;
        end
      end
      ST_RUN: begin
        if (!end_t) begin
          t_d = t_q + 1'b1;
        end else begin
          t_d = '0;
          if (!end_c) begin
            c_d = c_q + 1'b1;
          end else begin
            c_d = '0;
            if (!end_r) begin
              r_d = r_q + 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q <= '0;
      c_q <= '0;
      t_q <= '0;
    end else begin
      state_q <= state_d;
      r_q <= r_d;
      c_q <= c_d;
      t_q <= t_d;
    end
  end

  // The chain stays busy while the sequencer runs or results are in flight.
  logic [2:0] drain_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= '0;
    end else begin
      drain_q <= {drain_q[1:0], (state_q == ST_RUN)};
    end
  end

  assign busy_o = (state_q == ST_RUN) || (|drain_q);
  assign t_o = t_q;
  assign ctl_o.valid = (state_q == ST_RUN);
  assign ctl_o.first = (t_q == '0);
  assign ctl_o.last_t = end_t;
  assign ctl_o.row = r_q;
  assign ctl_o.col = c_q;
  assign ctl_o.last_res = end_t && end_c && end_r;

endmodule
